/* rtl/mfmc_pkg.sv */
// Package for the max-flow / min-cut engine: sizes, constants and word types.
// No dependencies; used by max_flow_min_cut_engine_unit and its testbench.
`default_nettype none
package mfmc_pkg;
    localparam int VTX_MAX   = 16;
    localparam int VTX_BITS  = 4;
    localparam int CNT_BITS  = 5;
    localparam int ADDR_BITS = 2 * VTX_BITS;
    localparam int MEM_DEPTH = VTX_MAX * VTX_MAX;
    localparam int CAP_BITS  = 16;
    localparam int RES_BITS  = CAP_BITS + 1;
    localparam logic [RES_BITS-1:0] BN_INIT = RES_BITS'((64'd1 << CAP_BITS) - 64'd1);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    typedef struct packed {
        logic                func;
        logic [VTX_BITS-1:0] row_vertex;
        logic [VTX_BITS-1:0] col_vertex;
        logic [CAP_BITS-1:0] capacity;
        logic [VTX_BITS-1:0] source_vertex;
        logic [VTX_BITS-1:0] sink_vertex;
    } t_in_word;

    typedef struct packed {
        logic [VTX_BITS-1:0] cut_from;
        logic [VTX_BITS-1:0] cut_to;
        logic                edge_valid;
        logic                bad_request;
        logic                last;
    } t_out_word;
endpackage
`default_nettype wire

/* rtl/max_flow_min_cut_engine_unit.sv */
// Max-flow / min-cut engine (Edmonds-Karp), top level; uses mfmc_pkg, mfmc_ram.
// Operation: a load word writes one capacity entry. A run word copies the capacity matrix into
// the residual RAM, then repeats BFS passes (scanning the row of each dequeued vertex) and
// augmenting path updates, then scans for cut edges and sends the final word; input is stalled
// while a run is in progress, output stalls hold the cut scan, and the residual RAM port serialises the steps.
// A rejected run's answer word is valid in the cycle after acceptance.
// Reset (sync, active low) clears control and sets vertex_count to 16; RAMs are not cleared.
`default_nettype none
module max_flow_min_cut_engine_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire mfmc_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output mfmc_pkg::t_out_word     o_out_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [4:0]         i_cfg_data
);
    import mfmc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_COPY, S_BINIT, S_POP, S_SCAN, S_BRD, S_BEV,
        S_URD, S_UWR1, S_UWR2, S_CUT, S_CEND
    } t_state;

    t_state              r_state;
    logic [4:0]          r_vcnt;
    logic [8:0]          r_cnt;        // copy address counter
    logic                r_cp_wv;
    logic [ADDR_BITS-1:0] r_cp_wa;
    logic [VTX_BITS-1:0] r_src, r_dst;
    logic [CNT_BITS-1:0] r_nv;
    logic [VTX_MAX-1:0]  r_reach;
    logic [VTX_BITS-1:0] r_pred  [VTX_MAX];
    logic [VTX_BITS-1:0] r_queue [VTX_MAX];
    logic [CNT_BITS-1:0] r_head, r_tail;
    logic [VTX_BITS-1:0] r_u;
    logic [CNT_BITS-1:0] r_sv;         // scan issue index
    logic                r_pv;         // scan read in flight
    logic [VTX_BITS-1:0] r_pvx;
    logic [VTX_BITS-1:0] r_v;          // path walk vertex
    logic [RES_BITS-1:0] r_bn;
    logic [CNT_BITS-1:0] r_ci, r_cj;   // cut scan issue indices
    logic                r_hv;         // cut read in flight
    logic [VTX_BITS-1:0] r_hx, r_hy;
    logic                r_pend_vld;   // cut edge held back until we know if it is last
    logic [VTX_BITS-1:0] r_pend_from, r_pend_to;
    logic                r_ovld;
    t_out_word           r_oword;

    logic [CNT_BITS-1:0] nv_eff;
    logic                accept, ofree, bad, scan_iss, cut_iss, hit, blk;
    logic [VTX_BITS-1:0] pv;
    logic                cap_we, cap_re, res_we, res_re;
    logic [ADDR_BITS-1:0] cap_wa, cap_ra, res_wa, res_ra;
    logic [CAP_BITS-1:0] cap_wd, cap_rd;
    logic [RES_BITS-1:0] res_wd, res_rd;

    assign ofree       = !r_ovld || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || (i_in_word.func == FUNC_RUN && !ofree);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovld;
    assign o_out_word  = r_oword;

    // vertex_count above the matrix size saturates
    assign nv_eff = (r_vcnt > CNT_BITS'(VTX_MAX)) ? CNT_BITS'(VTX_MAX) : r_vcnt;
    assign bad    = (i_in_word.source_vertex == i_in_word.sink_vertex)
                 || ({1'b0, i_in_word.source_vertex} >= nv_eff)
                 || ({1'b0, i_in_word.sink_vertex} >= nv_eff);

    assign pv       = r_pred[r_v];
    assign scan_iss = (r_state == S_SCAN) && (r_sv < r_nv);
    assign cut_iss  = (r_state == S_CUT) && (r_ci < r_nv);
    // cut edge: original capacity nonzero, source side to sink side
    assign hit = r_hv && r_reach[r_hx] && !r_reach[r_hy] && (cap_rd != '0);
    assign blk = hit && r_pend_vld && !ofree;

    // RAM port steering
    always_comb begin
        cap_we = accept && (i_in_word.func == FUNC_LOAD);
        cap_wa = {i_in_word.row_vertex, i_in_word.col_vertex};
        cap_wd = i_in_word.capacity;
        cap_re = 1'b0;
        cap_ra = {r_ci[VTX_BITS-1:0], r_cj[VTX_BITS-1:0]};
        res_we = 1'b0;
        res_wa = r_cp_wa;
        res_wd = {1'b0, cap_rd};
        res_re = 1'b0;
        res_ra = {pv, r_v};
        case (r_state)
            S_COPY: begin
                cap_re = (r_cnt < 9'(MEM_DEPTH));
                cap_ra = r_cnt[ADDR_BITS-1:0];
            end
            S_SCAN: begin
                res_re = scan_iss;
                res_ra = {r_u, r_sv[VTX_BITS-1:0]};
            end
            S_BRD, S_URD: begin
                res_re = 1'b1;
            end
            S_UWR1: begin
                res_we = 1'b1;
                res_wa = {pv, r_v};
                res_wd = res_rd - r_bn;
                res_re = 1'b1;
                res_ra = {r_v, pv};
            end
            S_UWR2: begin
                res_we = 1'b1;
                res_wa = {r_v, pv};
                res_wd = res_rd + r_bn;
            end
            S_CUT: begin
                cap_re = cut_iss && !blk;
            end
            default: begin
            end
        endcase
        if (r_cp_wv) begin
            res_we = 1'b1;
            res_wa = r_cp_wa;
            res_wd = {1'b0, cap_rd};
        end
    end

    mfmc_ram #(.WIDTH(CAP_BITS), .DEPTH(MEM_DEPTH)) u_cap_ram (
        .i_clk    (i_clk),
        .i_wr_en  (cap_we),
        .i_wr_addr(cap_wa),
        .i_wr_data(cap_wd),
        .i_rd_en  (cap_re),
        .i_rd_addr(cap_ra),
        .o_rd_data(cap_rd)
    );

    mfmc_ram #(.WIDTH(RES_BITS), .DEPTH(MEM_DEPTH)) u_res_ram (
        .i_clk    (i_clk),
        .i_wr_en  (res_we),
        .i_wr_addr(res_wa),
        .i_wr_data(res_wd),
        .i_rd_en  (res_re),
        .i_rd_addr(res_ra),
        .o_rd_data(res_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vcnt     <= 5'(VTX_MAX);
            r_cp_wv    <= 1'b0;
            r_reach    <= '0;
            r_pv       <= 1'b0;
            r_hv       <= 1'b0;
            r_pend_vld <= 1'b0;
            r_ovld     <= 1'b0;
            r_bn       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcnt <= i_cfg_data;
            end
            if (r_ovld && !i_out_stall) begin
                r_ovld <= 1'b0;
            end
            r_cp_wv <= (r_state == S_COPY) && (r_cnt < 9'(MEM_DEPTH));
            r_cp_wa <= r_cnt[ADDR_BITS-1:0];

            case (r_state)
                S_IDLE: begin
                    if (accept && i_in_word.func == FUNC_RUN) begin
                        if (bad) begin
                            r_ovld  <= 1'b1;
                            r_oword <= '{cut_from: '0, cut_to: '0, edge_valid: 1'b0,
                                         bad_request: 1'b1, last: 1'b1};
                        end else begin
                            r_src   <= i_in_word.source_vertex;
                            r_dst   <= i_in_word.sink_vertex;
                            r_nv    <= nv_eff;
                            r_cnt   <= '0;
                            r_state <= S_COPY;
                        end
                    end
                end
                S_COPY: begin
                    if (r_cnt == 9'(MEM_DEPTH)) begin
                        r_state <= S_BINIT;
                    end else begin
                        r_cnt <= r_cnt + 9'd1;
                    end
                end
                S_BINIT: begin
                    r_reach        <= VTX_MAX'(1) << r_src;
                    r_queue[0]     <= r_src;
                    r_pred[r_src]  <= r_src;
                    r_head         <= '0;
                    r_tail         <= CNT_BITS'(1);
                    r_state        <= S_POP;
                end
                S_POP: begin
                    if (r_head < r_tail) begin
                        r_u     <= r_queue[r_head[VTX_BITS-1:0]];
                        r_head  <= r_head + CNT_BITS'(1);
                        r_sv    <= '0;
                        r_pv    <= 1'b0;
                        r_state <= S_SCAN;
                    end else if (r_reach[r_dst]) begin
                        r_v     <= r_dst;
                        r_bn    <= BN_INIT;
                        r_state <= S_BRD;
                    end else begin
                        r_ci       <= '0;
                        r_cj       <= '0;
                        r_hv       <= 1'b0;
                        r_pend_vld <= 1'b0;
                        r_state    <= S_CUT;
                    end
                end
                S_SCAN: begin
                    r_pv  <= scan_iss;
                    r_pvx <= r_sv[VTX_BITS-1:0];
                    if (scan_iss) begin
                        r_sv <= r_sv + CNT_BITS'(1);
                    end
                    if (r_pv && !r_reach[r_pvx] && res_rd != '0) begin
                        if (r_tail < CNT_BITS'(VTX_MAX)) begin
                            r_queue[r_tail[VTX_BITS-1:0]] <= r_pvx;
                            r_tail <= r_tail + CNT_BITS'(1);
                        end
                        r_pred[r_pvx]  <= r_u;
                        r_reach[r_pvx] <= 1'b1;
                    end
                    if (!scan_iss && !r_pv) begin
                        r_state <= S_POP;
                    end
                end
                S_BRD: begin
                    r_state <= S_BEV;
                end
                S_BEV: begin
                    if (res_rd < r_bn) begin
                        r_bn <= res_rd;
                    end
                    if (pv == r_src) begin
                        r_v     <= r_dst;
                        r_state <= S_URD;
                    end else begin
                        r_v     <= pv;
                        r_state <= S_BRD;
                    end
                end
                S_URD: begin
                    r_state <= S_UWR1;
                end
                S_UWR1: begin
                    r_state <= S_UWR2;
                end
                S_UWR2: begin
                    r_v     <= pv;
                    r_state <= (pv == r_src) ? S_BINIT : S_URD;
                end
                S_CUT: begin
                    if (!blk) begin
                        r_hv <= cut_iss;
                        r_hx <= r_ci[VTX_BITS-1:0];
                        r_hy <= r_cj[VTX_BITS-1:0];
                        if (cut_iss) begin
                            if (r_cj + CNT_BITS'(1) == r_nv) begin
                                r_cj <= '0;
                                r_ci <= r_ci + CNT_BITS'(1);
                            end else begin
                                r_cj <= r_cj + CNT_BITS'(1);
                            end
                        end
                        if (hit) begin
                            if (r_pend_vld) begin
                                r_ovld  <= 1'b1;
                                r_oword <= '{cut_from: r_pend_from, cut_to: r_pend_to,
                                             edge_valid: 1'b1, bad_request: 1'b0,
                                             last: 1'b0};
                            end
                            r_pend_vld  <= 1'b1;
                            r_pend_from <= r_hx;
                            r_pend_to   <= r_hy;
                        end
                        if (!cut_iss && !r_hv) begin
                            r_state <= S_CEND;
                        end
                    end
                end
                S_CEND: begin
                    if (ofree) begin
                        r_ovld <= 1'b1;
                        if (r_pend_vld) begin
                            r_oword <= '{cut_from: r_pend_from, cut_to: r_pend_to,
                                         edge_valid: 1'b1, bad_request: 1'b0, last: 1'b1};
                        end else begin
                            // empty cut: one marker word
                            r_oword <= '{cut_from: '0, cut_to: '0, edge_valid: 1'b0,
                                         bad_request: 1'b0, last: 1'b1};
                        end
                        r_pend_vld <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/mfmc_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module mfmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

/* test/max_flow_min_cut_engine_unit_tb.sv */
// Testbench for the max-flow / min-cut engine: capacity loads, cut runs, vertex_count writes.
// Depends on mfmc_pkg and max_flow_min_cut_engine_unit; self-checking with its own cut predictor.
`timescale 1ns / 1ps
`default_nettype none

// Holds the capacity matrix as the block should see it and predicts cut words.
class cut_scoreboard;
    logic [15:0] cap_mat [16][16];
    bit          written [16][16];
    int          nv_reg;
    mfmc_pkg::t_out_word cut_q [$];
    int          errors;
    int          words_checked;

    function void clear();
        foreach (cap_mat[i, j]) begin
            cap_mat[i][j] = '0;
            written[i][j] = 0;
        end
        nv_reg = 16;
        errors = 0;
        words_checked = 0;
    endfunction

    function void note_cfg(logic [4:0] value);
        nv_reg = value;
    endfunction

    // Edmonds-Karp on a private residual copy; pushes the expected cut words.
    function void note_input(mfmc_pkg::t_in_word w);
        int nv, s, t, u, v, head, tail, n;
        logic [16:0] res [16][16];
        logic [16:0] bn;
        bit reached [16];
        int pred [16];
        int fifo [16];
        bit found;
        mfmc_pkg::t_out_word o;
        if (w.func == mfmc_pkg::FUNC_LOAD) begin
            cap_mat[w.row_vertex][w.col_vertex] = w.capacity;
            written[w.row_vertex][w.col_vertex] = 1;
            return;
        end
        nv = nv_reg > 16 ? 16 : nv_reg;
        s = w.source_vertex;
        t = w.sink_vertex;
        o = '0;
        if (s == t || s >= nv || t >= nv) begin
            o.bad_request = 1'b1;
            o.last = 1'b1;
            cut_q.push_back(o);
            return;
        end
        foreach (res[i, j]) res[i][j] = {1'b0, cap_mat[i][j]};
        found = 1;
        while (found) begin
            foreach (reached[i]) reached[i] = 0;
            head = 0;
            tail = 0;
            fifo[tail++] = s;
            reached[s] = 1;
            pred[s] = s;
            while (head < tail) begin
                u = fifo[head++];
                for (v = 0; v < nv; v++) begin
                    if (!reached[v] && res[u][v] != 0) begin
                        if (tail < 16) fifo[tail++] = v;
                        pred[v] = u;
                        reached[v] = 1;
                    end
                end
            end
            found = reached[t];
            if (found) begin
                bn = mfmc_pkg::BN_INIT;
                for (v = t; v != s; v = pred[v])
                    if (res[pred[v]][v] < bn) bn = res[pred[v]][v];
                for (v = t; v != s; v = pred[v]) begin
                    res[pred[v]][v] -= bn;
                    res[v][pred[v]] += bn;
                end
            end
        end
        n = 0;
        for (int i = 0; i < nv; i++) begin
            for (int j = 0; j < nv; j++) begin
                if (reached[i] && !reached[j] && cap_mat[i][j] != 0 && n < 64) begin
                    o = '0;
                    o.cut_from = i;
                    o.cut_to = j;
                    o.edge_valid = 1'b1;
                    cut_q.push_back(o);
                    n++;
                end
            end
        end
        if (n == 0) cut_q.push_back('0);
        o = cut_q.pop_back();
        o.last = 1'b1;
        cut_q.push_back(o);
    endfunction

    task check_output(mfmc_pkg::t_out_word got);
        mfmc_pkg::t_out_word want;
        words_checked++;
        if (cut_q.size() == 0) begin
            report_mismatch("unexpected word", '0, got);
            return;
        end
        want = cut_q.pop_front();
        if (got.cut_from !== want.cut_from) report_mismatch("cut_from", want, got);
        if (got.cut_to !== want.cut_to) report_mismatch("cut_to", want, got);
        if (got.edge_valid !== want.edge_valid) report_mismatch("edge_valid", want, got);
        if (got.bad_request !== want.bad_request) report_mismatch("bad_request", want, got);
        if (got.last !== want.last) report_mismatch("last", want, got);
    endtask

    task report_mismatch(string what, mfmc_pkg::t_out_word want,
                         mfmc_pkg::t_out_word got);
        errors++;
        if (errors <= 30)
            $display("%0t ERROR %s: expected %h got %h", $realtime, what, want, got);
    endtask
endclass

module max_flow_min_cut_engine_unit_tb;
    import mfmc_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [4:0] i_cfg_data;

    cut_scoreboard sb;
    int idle_pct;        // sender idle chance, percent
    int stall_pct;       // receiver stall chance, percent
    int n_runs;
    int n_loads;
    int n_edges;

    max_flow_min_cut_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Receiver: random stall, check each accepted word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_output(o_out_word);
                if (o_out_word.edge_valid) n_edges++;
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Sends one word, with a random idle gap before it; valid stays up when words follow.
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            if (i_in_valid) i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(w);
        if (w.func == FUNC_RUN) n_runs++;
        else n_loads++;
    endtask

    task automatic load_cap(int r, int c, logic [15:0] cap);
        t_in_word w;
        w = $urandom;
        w.func = FUNC_LOAD;
        w.row_vertex = r;
        w.col_vertex = c;
        w.capacity = cap;
        send_word(w);
    endtask

    task automatic run_cut(int s, int t);
        t_in_word w;
        w = $urandom;
        w.func = FUNC_RUN;
        w.source_vertex = s;
        w.sink_vertex = t;
        send_word(w);
    endtask

    // Drops valid, waits until every predicted word has come, plus a settle margin.
    task automatic drain();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (sb.cut_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [4:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_cfg(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Writes columns 0..cols-1 of one row; sparse, random.
    task automatic fill_row(int r, int cols, int density);
        for (int c = 0; c < cols; c++)
            load_cap(r, c, (r != c && $urandom_range(99) < density) ?
                     16'($urandom_range(1, 20)) : 16'd0);
    endtask

    // Writes the top-left size x size block, which is all a run with that vertex count reads.
    task automatic fill_matrix(int size, int density);
        for (int r = 0; r < size; r++)
            fill_row(r, size, density);
    endtask

    initial begin
        int nv;
        sb = new();
        sb.clear();
        idle_pct = 0;
        stall_pct = 0;
        n_runs = 0;
        n_loads = 0;
        n_edges = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 5'd16;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero rows 0, 1 and 15 (all the full-size runs below touch), then extremes.
        fill_row(0, 16, 0);
        fill_row(1, 16, 0);
        fill_row(15, 16, 0);
        run_cut(0, 15);                 // empty cut
        run_cut(3, 3);                  // source equals sink
        load_cap(0, 15, 16'hffff);
        load_cap(15, 0, 16'h0001);
        load_cap(0, 1, 16'h8000);
        load_cap(1, 15, 16'h7fff);
        run_cut(0, 15);                 // cut edges after saturation
        run_cut(15, 0);
        write_cfg(5'd2);                // smallest legal graph
        run_cut(0, 1);
        run_cut(0, 2);                  // sink out of range
        write_cfg(5'd1);                // every run rejected
        run_cut(0, 1);
        write_cfg(5'd31);               // saturates to 16
        run_cut(1, 0);
        write_cfg(5'd0);
        run_cut(15, 14);

        // Random phases: config change, matrix refill, runs and occasional loads, with varied idling and stalling.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 67; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 67; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            nv = $urandom_range(5, 8);
            write_cfg(5'(nv));
            fill_matrix(nv, ph * 10 + 15);
            repeat (20) begin
                if ($urandom_range(9) == 0) run_cut($urandom_range(15), $urandom_range(15));
                else run_cut($urandom_range(nv - 1), $urandom_range(nv - 1));
                if ($urandom_range(3) == 0)
                    load_cap($urandom_range(15), $urandom_range(15), 16'($urandom));
            end
            drain();                    // sender holds off until all words are back
        end
        write_cfg(5'd16);
        run_cut(3, 3);
        drain();
        repeat (300) @(posedge i_clk);

        $display("Covered %0d loads, %0d cut runs, %0d cut edges, %0d words checked.",
                 n_loads, n_runs, n_edges, sb.words_checked);
        if (sb.errors == 0 && sb.cut_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout with %0d words outstanding", sb.cut_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire

/* max_flow_min_cut_engine_unit.f */
rtl/mfmc_pkg.sv
rtl/mfmc_ram.sv
rtl/max_flow_min_cut_engine_unit.sv
test/max_flow_min_cut_engine_unit_tb.sv
